[sv/esde_pkg.sv]
// Shared types, register indexes and datapath op codes for the encoder speed estimator.
package esde_pkg;

  // Configuration port geometry
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT_SPEED_GAIN       = 3'd0,
    REG_RIGHT_SPEED_GAIN      = 3'd1,
    REG_CENTIMETRE_FACTOR     = 3'd2,
    REG_TICK_PERIOD           = 3'd3,
    REG_PULSES_PER_CENTIMETRE = 3'd4,
    REG_LEFT_INVERT           = 3'd5,
    REG_RIGHT_INVERT          = 3'd6
  } esde_reg_t;

  // Register reset values
  localparam logic [23:0] RST_LEFT_SPEED_GAIN       = 24'd65536;
  localparam logic [23:0] RST_RIGHT_SPEED_GAIN      = 24'd65536;
  localparam logic [9:0]  RST_CENTIMETRE_FACTOR     = 10'd100;
  localparam logic [9:0]  RST_TICK_PERIOD           = 10'd5;
  localparam logic [15:0] RST_PULSES_PER_CENTIMETRE = 16'd256;
  localparam logic        RST_LEFT_INVERT           = 1'b0;
  localparam logic        RST_RIGHT_INVERT          = 1'b1;

  typedef struct packed {
    logic [23:0] left_speed_gain;
    logic [23:0] right_speed_gain;
    logic [9:0]  centimetre_factor;
    logic [9:0]  tick_period;
    logic [15:0] pulses_per_centimetre;
    logic        left_invert;
    logic        right_invert;
  } esde_cfg_t;

  typedef struct packed {
    logic signed [15:0] left_pulses;
    logic signed [15:0] right_pulses;
  } esde_in_t;

  typedef struct packed {
    logic signed [31:0] left_speed;
    logic signed [31:0] right_speed;
    logic signed [31:0] car_speed;
    logic signed [31:0] car_speed_cm;
    logic signed [31:0] left_total;
    logic signed [31:0] right_total;
    logic signed [31:0] car_distance;
    logic signed [31:0] left_distance;
    logic signed [31:0] right_distance;
  } esde_out_t;

  // Datapath operations issued by the controller, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,      // capture samples, read window slot
    OP_SUM,       // update window sums and window memory
    OP_MUL_LS,    // left sum * left gain
    OP_MUL_RS,    // right sum * right gain
    OP_MUL_LD,    // left speed * tick period
    OP_MUL_RD,    // right speed * tick period
    OP_MUL_CD,    // car speed * tick period
    OP_MUL_CM,    // car speed * centimetre factor
    OP_MUL_PL,    // left distance acc * pulses per cm
    OP_MUL_PR,    // right distance acc * pulses per cm
    OP_MUL_PC     // car distance acc * pulses per cm
  } esde_op_t;

  typedef struct packed {
    esde_op_t op;
    logic     load_out;
  } esde_cmd_t;

endpackage

[sv/esde_cfg.sv]
// Configuration register file for the encoder speed estimator.
module esde_cfg import esde_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output esde_cfg_t             cfg
);

  esde_cfg_t cfg_r;

  // Decode the write and update the addressed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.left_speed_gain       <= RST_LEFT_SPEED_GAIN;
      cfg_r.right_speed_gain      <= RST_RIGHT_SPEED_GAIN;
      cfg_r.centimetre_factor     <= RST_CENTIMETRE_FACTOR;
      cfg_r.tick_period           <= RST_TICK_PERIOD;
      cfg_r.pulses_per_centimetre <= RST_PULSES_PER_CENTIMETRE;
      cfg_r.left_invert           <= RST_LEFT_INVERT;
      cfg_r.right_invert          <= RST_RIGHT_INVERT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LEFT_SPEED_GAIN:       cfg_r.left_speed_gain       <= cfg_wdata[23:0];
        REG_RIGHT_SPEED_GAIN:      cfg_r.right_speed_gain      <= cfg_wdata[23:0];
        REG_CENTIMETRE_FACTOR:     cfg_r.centimetre_factor     <= cfg_wdata[9:0];
        REG_TICK_PERIOD:           cfg_r.tick_period           <= cfg_wdata[9:0];
        REG_PULSES_PER_CENTIMETRE: cfg_r.pulses_per_centimetre <= cfg_wdata[15:0];
        REG_LEFT_INVERT:           cfg_r.left_invert           <= cfg_wdata[0];
        REG_RIGHT_INVERT:          cfg_r.right_invert          <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[sv/esde_ctrl.sv]
// Controller state machine: sequences one beat through the shared multiplier.
module esde_ctrl import esde_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output esde_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_MLS,
    ST_MRS,
    ST_MLD,
    ST_MRD,
    ST_MCD,
    ST_MCM,
    ST_MPL,
    ST_MPR,
    ST_MPC,
    ST_DONE
  } state_t;

  state_t state_r;
  logic   in_stall_r;
  logic   out_valid_r;

  // Map state to the datapath operation
  always_comb begin
    cmd.op       = OP_NONE;
    cmd.load_out = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
    unique case (state_r)
      ST_IDLE: cmd.op = in_valid ? OP_LOAD : OP_NONE;
      ST_SUM:  cmd.op = OP_SUM;
      ST_MLS:  cmd.op = OP_MUL_LS;
      ST_MRS:  cmd.op = OP_MUL_RS;
      ST_MLD:  cmd.op = OP_MUL_LD;
      ST_MRD:  cmd.op = OP_MUL_RD;
      ST_MCD:  cmd.op = OP_MUL_CD;
      ST_MCM:  cmd.op = OP_MUL_CM;
      ST_MPL:  cmd.op = OP_MUL_PL;
      ST_MPR:  cmd.op = OP_MUL_PR;
      ST_MPC:  cmd.op = OP_MUL_PC;
      ST_DONE: cmd.op = OP_NONE;
      default: cmd.op = OP_NONE;
    endcase
  end

  // Advance the sequence, hold the input stall and the output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_stall_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            state_r    <= ST_SUM;
            in_stall_r <= 1'b1;
          end
        end
        ST_SUM:  state_r <= ST_MLS;
        ST_MLS:  state_r <= ST_MRS;
        ST_MRS:  state_r <= ST_MLD;
        ST_MLD:  state_r <= ST_MRD;
        ST_MRD:  state_r <= ST_MCD;
        ST_MCD:  state_r <= ST_MCM;
        ST_MCM:  state_r <= ST_MPL;
        ST_MPL:  state_r <= ST_MPR;
        ST_MPR:  state_r <= ST_MPC;
        ST_MPC:  state_r <= ST_DONE;
        ST_DONE: begin
          if (cmd.load_out) begin
            state_r    <= ST_IDLE;
            in_stall_r <= 1'b0;
          end
        end
        default: state_r <= ST_IDLE;
      endcase

      // Output beat: set on load, drop once taken
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_stall  = in_stall_r;
  assign out_valid = out_valid_r;

endmodule

[sv/esde_dp.sv]
// Datapath: window memories, window sums, shared multiplier, accumulators, output register.
module esde_dp import esde_pkg::*; #(
  parameter int WINDOW_LENGTH = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  esde_cmd_t cmd,
  input  esde_cfg_t cfg,
  input  esde_in_t  in_data,
  output esde_out_t out_data
);

  localparam int SLOT_W = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
  localparam int SUM_W  = 16 + $clog2(WINDOW_LENGTH);
  localparam int ACC_W  = 48;
  localparam int MB_W   = 25;
  localparam int PROD_W = ACC_W + MB_W;

  localparam logic [SLOT_W-1:0]       LAST_SLOT = SLOT_W'(WINDOW_LENGTH - 1);
  localparam logic signed [SUM_W:0]   WIN_S     = (SUM_W + 1)'(WINDOW_LENGTH);
  localparam logic signed [15:0]      S16_MIN   = 16'sh8000;
  localparam logic signed [15:0]      S16_MAX   = 16'sh7FFF;
  localparam logic signed [PROD_W-1:0] RND16    = PROD_W'(65535);
  localparam logic signed [PROD_W-1:0] RND24    = PROD_W'(16777215);
  localparam logic signed [ACC_W-1:0] ACC_MAX   = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN   = {1'b1, {(ACC_W-1){1'b0}}};

  // Negate on request; the most negative count clips to the most positive
  function automatic logic signed [15:0] take_sample(input logic signed [15:0] raw,
                                                     input logic inv);
    if (!inv) begin
      return raw;
    end
    return (raw == S16_MIN) ? S16_MAX : -raw;
  endfunction

  // Clip a wide value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
    if ((&v[PROD_W-1:31]) || !(|v[PROD_W-1:31])) begin
      return v[31:0];
    end
    return v[PROD_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  endfunction

  // Product / 2^8, floored, clipped: Q16.16 speed
  function automatic logic signed [31:0] speed_of(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p >>> 8;
    return sat32(t);
  endfunction

  // Product / 2^16 toward zero, clipped
  function automatic logic signed [31:0] to_cm(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p + (p[PROD_W-1] ? RND16 : '0);
    t = t >>> 16;
    return sat32(t);
  endfunction

  // Product / 2^24 toward zero, clipped
  function automatic logic signed [31:0] to_pulses(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p + (p[PROD_W-1] ? RND24 : '0);
    t = t >>> 24;
    return sat32(t);
  endfunction

  // Add a speed * period step, clip to the accumulator range
  function automatic logic signed [ACC_W-1:0] acc_add(input logic signed [ACC_W-1:0] acc,
                                                      input logic signed [PROD_W-1:0] p);
    logic signed [ACC_W+1:0] s;
    s = (ACC_W + 2)'(acc) + $signed(p[ACC_W+1:0]);
    if ((&s[ACC_W+1:ACC_W-1]) || !(|s[ACC_W+1:ACC_W-1])) begin
      return s[ACC_W-1:0];
    end
    return s[ACC_W+1] ? ACC_MIN : ACC_MAX;
  endfunction

  // Window memories
  logic signed [15:0] lwin_mem [WINDOW_LENGTH];
  logic signed [15:0] rwin_mem [WINDOW_LENGTH];

  // Window state
  logic signed [15:0]       ls_r, rs_r;
  logic signed [15:0]       lrd_r, rrd_r;
  logic signed [15:0]       lprime_r, rprime_r;
  logic signed [SUM_W-1:0]  lsum_r, rsum_r;
  logic signed [SUM_W-1:0]  lsum_nxt, rsum_nxt;
  logic [SLOT_W-1:0]        slot_r;
  logic                     primed_r;
  logic                     filled_r;
  logic signed [31:0]       ltot_r, rtot_r;

  // Speeds, accumulators, converted results
  logic signed [31:0]       lsp_r, rsp_r, csp_r, ccm_r;
  logic signed [31:0]       ldist_r, rdist_r;
  logic signed [ACC_W-1:0]  ldacc_r, rdacc_r, cdacc_r;
  logic signed [PROD_W-1:0] prod_r;
  esde_out_t                out_r;

  // Shared multiplier
  logic signed [ACC_W-1:0]  mul_a;
  logic [23:0]              mul_b;
  logic signed [MB_W-1:0]   mul_b_s;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [32:0]       car_pair;

  // Select multiplier operands for this step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_MUL_LS: begin
        mul_a = ACC_W'(lsum_r);
        mul_b = cfg.left_speed_gain;
      end
      OP_MUL_RS: begin
        mul_a = ACC_W'(rsum_r);
        mul_b = cfg.right_speed_gain;
      end
      OP_MUL_LD: begin
        mul_a = ACC_W'(lsp_r);
        mul_b = 24'(cfg.tick_period);
      end
      OP_MUL_RD: begin
        mul_a = ACC_W'(rsp_r);
        mul_b = 24'(cfg.tick_period);
      end
      OP_MUL_CD: begin
        mul_a = ACC_W'(csp_r);
        mul_b = 24'(cfg.tick_period);
      end
      OP_MUL_CM: begin
        mul_a = ACC_W'(csp_r);
        mul_b = 24'(cfg.centimetre_factor);
      end
      OP_MUL_PL: begin
        mul_a = ldacc_r;
        mul_b = 24'(cfg.pulses_per_centimetre);
      end
      OP_MUL_PR: begin
        mul_a = rdacc_r;
        mul_b = 24'(cfg.pulses_per_centimetre);
      end
      OP_MUL_PC: begin
        mul_a = cdacc_r;
        mul_b = 24'(cfg.pulses_per_centimetre);
      end
      default: ;
    endcase
  end

  assign mul_b_s  = $signed({1'b0, mul_b});
  assign mul_p    = mul_a * mul_b_s;
  assign car_pair = 33'(lsp_r) + 33'(rsp_r);

  // Next window sums: first beat fills the window, later beats swap one entry
  always_comb begin
    if (!primed_r) begin
      lsum_nxt = SUM_W'(ls_r * WIN_S);
      rsum_nxt = SUM_W'(rs_r * WIN_S);
    end else begin
      lsum_nxt = lsum_r - SUM_W'(filled_r ? lrd_r : lprime_r) + SUM_W'(ls_r);
      rsum_nxt = rsum_r - SUM_W'(filled_r ? rrd_r : rprime_r) + SUM_W'(rs_r);
    end
  end

  // Window memories: read the slot on load, write it on the sum step once primed
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      lrd_r <= lwin_mem[slot_r];
      rrd_r <= rwin_mem[slot_r];
    end
    if (cmd.op == OP_SUM && primed_r) begin
      lwin_mem[slot_r] <= ls_r;
      rwin_mem[slot_r] <= rs_r;
    end
  end

  // Running state: sums, slot, totals, accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lsum_r   <= '0;
      rsum_r   <= '0;
      slot_r   <= '0;
      primed_r <= 1'b0;
      filled_r <= 1'b0;
      ltot_r   <= '0;
      rtot_r   <= '0;
      ldacc_r  <= '0;
      rdacc_r  <= '0;
      cdacc_r  <= '0;
    end else begin
      unique case (cmd.op)
        OP_SUM: begin
          lsum_r <= lsum_nxt;
          rsum_r <= rsum_nxt;
          if (!primed_r) begin
            primed_r <= 1'b1;
          end else begin
            slot_r <= (slot_r == LAST_SLOT) ? '0 : slot_r + 1'b1;
            if (slot_r == LAST_SLOT) begin
              filled_r <= 1'b1;
            end
          end
        end
        OP_MUL_LS: begin
          ltot_r <= ltot_r + 32'(lsum_r);
          rtot_r <= rtot_r + 32'(rsum_r);
        end
        OP_MUL_RD: ldacc_r <= acc_add(ldacc_r, prod_r);
        OP_MUL_CD: rdacc_r <= acc_add(rdacc_r, prod_r);
        OP_MUL_CM: cdacc_r <= acc_add(cdacc_r, prod_r);
        default: ;
      endcase
    end
  end

  // Payload: samples, product, speeds, converted results
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        ls_r <= take_sample(in_data.left_pulses, cfg.left_invert);
        rs_r <= take_sample(in_data.right_pulses, cfg.right_invert);
      end
      OP_SUM: begin
        if (!primed_r) begin
          lprime_r <= ls_r;
          rprime_r <= rs_r;
        end
      end
      OP_MUL_RS: lsp_r <= speed_of(prod_r);
      OP_MUL_LD: rsp_r <= speed_of(prod_r);
      OP_MUL_RD: csp_r <= car_pair[32:1];
      OP_MUL_PL: ccm_r <= to_cm(prod_r);
      OP_MUL_PR: ldist_r <= to_pulses(prod_r);
      OP_MUL_PC: rdist_r <= to_pulses(prod_r);
      default: ;
    endcase

    if (cmd.op == OP_MUL_LS || cmd.op == OP_MUL_RS || cmd.op == OP_MUL_LD ||
        cmd.op == OP_MUL_RD || cmd.op == OP_MUL_CD || cmd.op == OP_MUL_CM ||
        cmd.op == OP_MUL_PL || cmd.op == OP_MUL_PR || cmd.op == OP_MUL_PC) begin
      prod_r <= mul_p;
    end

    // Load the output beat
    if (cmd.load_out) begin
      out_r.left_speed     <= lsp_r;
      out_r.right_speed    <= rsp_r;
      out_r.car_speed      <= csp_r;
      out_r.car_speed_cm   <= ccm_r;
      out_r.left_total     <= ltot_r;
      out_r.right_total    <= rtot_r;
      out_r.car_distance   <= to_pulses(prod_r);
      out_r.left_distance  <= ldist_r;
      out_r.right_distance <= rdist_r;
    end
  end

  assign out_data = out_r;

endmodule

[sv/encoder_speed_distance_estimator_unit.sv]
// An accepted input beat passes the sum step and the multiply steps before its result is loaded; the
// last step holds for as long as an earlier result still waits on out_stall.
// Beats do not overlap: a single shared 48x25 multiplier runs nine products in turn.
// The output register lets the next input beat be taken while a result waits on out_stall.
// Reset (synchronous, rst_n low): window sums, slot, totals and distance accumulators clear,
// configuration returns to defaults; window memories need no clearing pass.
module encoder_speed_distance_estimator_unit import esde_pkg::*; #(
  parameter int WINDOW_LENGTH = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  esde_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output esde_out_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  esde_cfg_t cfg;
  esde_cmd_t cmd;

  esde_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  esde_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  esde_dp #(
    .WINDOW_LENGTH (WINDOW_LENGTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .cfg      (cfg),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

[sv/esde_checker.sv]
// Port-level checker for the encoder speed estimator, bound to the top level.
module esde_checker import esde_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input esde_out_t out_data
);

  // A stalled output beat stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("output beat dropped while stalled");

  // A stalled output beat keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("output payload changed while stalled");

  // An accepted beat still holds the input stalled at the last multiply step of its sequence
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> ##10 in_stall)
    else $error("input accepted before the previous beat finished");

  // A new result appears only at the end of a busy sequence
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result issued with no beat in progress");

endmodule

bind encoder_speed_distance_estimator_unit esde_checker u_esde_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

[test/encoder_speed_distance_estimator_checker.sv]
// Checker for the encoder estimator: predicts every result beat and compares it field by field.
`timescale 1ns / 1ps

module encoder_speed_distance_estimator_checker import esde_pkg::*; #(
  parameter int WINDOW_LENGTH = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  esde_in_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  esde_out_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    mismatches,
  output int                    pending
);

  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -S32_MAX - 1;
  localparam longint DIST_MAX = (longint'(1) <<< 47) - 1;
  localparam longint DIST_MIN = -DIST_MAX - 1;
  localparam int REPORT_LIMIT = 10;

  // Mirror of the register file and of the block's running state
  esde_cfg_t          regs;
  logic signed [15:0] left_win [WINDOW_LENGTH];
  logic signed [15:0] right_win [WINDOW_LENGTH];
  int                 slot;
  bit                 primed;
  logic [31:0]        left_sum_total, right_sum_total;
  longint             car_dist, left_dist, right_dist;
  esde_out_t          estimate_q [$];
  int                 err_cnt;

  string field_names [9] = '{"left_speed", "right_speed", "car_speed", "car_speed_cm",
                             "left_total", "right_total", "car_distance", "left_distance",
                             "right_distance"};

  function automatic longint sat32(input longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  // Negate on request; the most negative count clips to the most positive one
  function automatic logic signed [15:0] oriented(input logic signed [15:0] raw,
                                                 input logic inv);
    if (!inv) return raw;
    if (raw == 16'sh8000) return 16'sh7FFF;
    return -raw;
  endfunction

  // Q16.16 wheel speed: floor of sum * gain / 2^8, clipped to 32 bits
  function automatic longint wheel_speed(input longint sum, input logic [23:0] gain);
    return sat32((sum * longint'(gain)) >>> 8);
  endfunction

  // Integrate one tick of speed into a 48-bit saturating distance
  function automatic longint integrate(input longint acc, input longint spd);
    longint a;
    a = acc + spd * longint'(regs.tick_period);
    if (a > DIST_MAX) a = DIST_MAX;
    if (a < DIST_MIN) a = DIST_MIN;
    return a;
  endfunction

  function automatic longint pulse_count(input longint acc);
    return sat32((acc * longint'(regs.pulses_per_centimetre)) / 16777216);
  endfunction

  // Advance the model by one input beat and build the result it causes
  task automatic estimate_tick(input esde_in_t beat, output esde_out_t res);
    logic signed [15:0] ls, rs;
    longint lsum, rsum, lsp, rsp, csp;
    ls = oriented(beat.left_pulses, regs.left_invert);
    rs = oriented(beat.right_pulses, regs.right_invert);
    if (!primed) begin
      for (int i = 0; i < WINDOW_LENGTH; i++) begin
        left_win[i] = ls;
        right_win[i] = rs;
      end
      primed = 1'b1;
    end else begin
      left_win[slot] = ls;
      right_win[slot] = rs;
      slot = (slot + 1 >= WINDOW_LENGTH) ? 0 : slot + 1;
    end
    lsum = 0;
    rsum = 0;
    for (int i = 0; i < WINDOW_LENGTH; i++) begin
      lsum += longint'(left_win[i]);
      rsum += longint'(right_win[i]);
    end
    left_sum_total  = left_sum_total + lsum[31:0];
    right_sum_total = right_sum_total + rsum[31:0];
    lsp = wheel_speed(lsum, regs.left_speed_gain);
    rsp = wheel_speed(rsum, regs.right_speed_gain);
    csp = (lsp + rsp) >>> 1;
    car_dist   = integrate(car_dist, csp);
    left_dist  = integrate(left_dist, lsp);
    right_dist = integrate(right_dist, rsp);
    res.left_speed     = lsp[31:0];
    res.right_speed    = rsp[31:0];
    res.car_speed      = csp[31:0];
    res.car_speed_cm   = 32'(sat32((csp * longint'(regs.centimetre_factor)) / 65536));
    res.left_total     = left_sum_total;
    res.right_total    = right_sum_total;
    res.car_distance   = 32'(pulse_count(car_dist));
    res.left_distance  = 32'(pulse_count(left_dist));
    res.right_distance = 32'(pulse_count(right_dist));
  endtask

  always @(posedge clk) begin : watch
    esde_out_t         want, got;
    logic [8:0][31:0]  want_w, got_w;
    if (!rst_n) begin
      // Return to the reset state of the block
      regs.left_speed_gain       = RST_LEFT_SPEED_GAIN;
      regs.right_speed_gain      = RST_RIGHT_SPEED_GAIN;
      regs.centimetre_factor     = RST_CENTIMETRE_FACTOR;
      regs.tick_period           = RST_TICK_PERIOD;
      regs.pulses_per_centimetre = RST_PULSES_PER_CENTIMETRE;
      regs.left_invert           = RST_LEFT_INVERT;
      regs.right_invert          = RST_RIGHT_INVERT;
      for (int i = 0; i < WINDOW_LENGTH; i++) begin
        left_win[i] = '0;
        right_win[i] = '0;
      end
      slot = 0;
      primed = 1'b0;
      left_sum_total = '0;
      right_sum_total = '0;
      car_dist = 0;
      left_dist = 0;
      right_dist = 0;
      estimate_q.delete();
    end else begin
      // Compare a result beat with the oldest estimate
      if (out_valid && !out_stall) begin
        got = out_data;
        if (estimate_q.size() == 0) begin
          if (err_cnt < REPORT_LIMIT)
            $display("%0t: result beat with no estimate waiting: %h", $realtime, got);
          err_cnt++;
        end else begin
          want = estimate_q.pop_front();
          want_w = want;
          got_w = got;
          for (int i = 0; i < 9; i++) begin
            if (got_w[8-i] !== want_w[8-i]) begin
              if (err_cnt < REPORT_LIMIT)
                $display("%0t: %s expected %0d (%h) got %0d (%h)", $realtime, field_names[i],
                         $signed(want_w[8-i]), want_w[8-i], $signed(got_w[8-i]),
                         got_w[8-i]);
              err_cnt++;
            end
          end
        end
      end
      // Track register writes
      if (cfg_we) begin
        case (esde_reg_t'(cfg_index))
          REG_LEFT_SPEED_GAIN:       regs.left_speed_gain = cfg_wdata;
          REG_RIGHT_SPEED_GAIN:      regs.right_speed_gain = cfg_wdata;
          REG_CENTIMETRE_FACTOR:     regs.centimetre_factor = cfg_wdata[9:0];
          REG_TICK_PERIOD:           regs.tick_period = cfg_wdata[9:0];
          REG_PULSES_PER_CENTIMETRE: regs.pulses_per_centimetre = cfg_wdata[15:0];
          REG_LEFT_INVERT:           regs.left_invert = cfg_wdata[0];
          REG_RIGHT_INVERT:          regs.right_invert = cfg_wdata[0];
          default: ;
        endcase
      end
      // Predict the result of an accepted input beat
      if (in_valid && !in_stall) begin
        estimate_tick(in_data, want);
        estimate_q.push_back(want);
      end
    end
    mismatches <= err_cnt;
    pending <= estimate_q.size();
  end

  initial err_cnt = 0;

endmodule

[test/encoder_speed_distance_estimator_unit_tb.sv]
// Testbench top for the encoder estimator: clock, reset, stimulus, register phases and verdict.
`timescale 1ns / 1ps

module encoder_speed_distance_estimator_unit_tb import esde_pkg::*;;

  localparam int RESET_CYCLES   = 10;
  localparam int PHASES         = 9;
  localparam int PHASE_BEATS    = 128;
  localparam int FLOOR_BEATS    = 150;
  localparam int HOLD_AT        = 200;
  localparam int HOLD_CYCLES    = 300;
  localparam int CALM_FROM      = 600;
  localparam int CALM_TO        = 760;
  localparam int SETTLE_CYCLES  = 16;
  localparam int TAIL_CYCLES    = 40;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef enum int {DRIVE_NOISE, DRIVE_CRUISE, DRIVE_EXTREME, DRIVE_FLOOR} drive_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  esde_in_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  esde_out_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int  mismatches;
  int  pending;
  int  in_beats = 0;
  int  quiet_cycles = 0;
  wire calm = (in_beats >= CALM_FROM) && (in_beats < CALM_TO);

  // Directed beats: left count in the upper half, right count in the lower half
  logic [31:0] directed_beats [14] = '{
    32'h0000_0000, 32'h7FFF_8000, 32'h8000_7FFF, 32'h8000_8000, 32'h7FFF_7FFF,
    32'h0001_FFFF, 32'hFFFF_0001, 32'h5555_AAAA, 32'hAAAA_5555, 32'h0064_FF9C,
    32'h0064_FF9C, 32'h0000_0000, 32'h7FFF_8000, 32'h8000_7FFF};

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  encoder_speed_distance_estimator_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  encoder_speed_distance_estimator_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // Count accepted input beats and end the run if both channels go quiet too long
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) in_beats <= in_beats + 1;
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: random stalls, one long hold-off, no stalls in the calm stretch
  initial begin : receiver
    int  hold_left;
    bit  held;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && in_beats >= HOLD_AT) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 9);
      end
    end
  end

  // Offer one beat, after a random gap, and hold it until accepted
  task automatic send_beat(input esde_in_t beat);
    while (!calm && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop sending and wait for every estimate to be matched
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input esde_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_extreme();
    case ($urandom_range(6))
      0: return 16'h8000;
      1: return 16'h8001;
      2: return 16'hFFFF;
      3: return 16'h0000;
      4: return 16'h0001;
      5: return 16'h7FFE;
      default: return 16'h7FFF;
    endcase
  endfunction

  initial begin : stimulus
    esde_in_t              beat;
    drive_t                mode;
    logic [23:0]           lgain, rgain;
    logic [9:0]            cm_factor, period;
    logic [15:0]           ppcm;
    logic                  linv, rinv;
    int                    cruise_l, cruise_r, floor_dir, pick;
    bit                    floor_phase;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats under the reset settings
    foreach (directed_beats[i]) send_beat(directed_beats[i]);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      floor_dir = 0;
      floor_phase = 1'b0;
      lgain = RST_LEFT_SPEED_GAIN;
      rgain = RST_RIGHT_SPEED_GAIN;
      cm_factor = RST_CENTIMETRE_FACTOR;
      period = RST_TICK_PERIOD;
      ppcm = RST_PULSES_PER_CENTIMETRE;
      linv = RST_LEFT_INVERT;
      rinv = RST_RIGHT_INVERT;
      case (p)
        1, 5: begin
          // Full scale: drive the distance integrators into saturation
          lgain = '1;
          rgain = '1;
          cm_factor = '1;
          period = '1;
          ppcm = '1;
          linv = 1'b0;
          rinv = 1'b1;
          floor_dir = (p == 1) ? 1 : -1;
          floor_phase = 1'b1;
        end
        2: begin
          lgain = '0;
          rgain = '0;
          cm_factor = '0;
          period = '0;
          ppcm = '0;
          linv = 1'b0;
          rinv = 1'b0;
        end
        3: begin
          lgain = 24'd1;
          rgain = 24'd1;
          cm_factor = 10'd1;
          period = 10'd1;
          ppcm = 16'd1;
          linv = 1'b1;
          rinv = 1'b0;
        end
        4: begin
          lgain = 24'($urandom());
          rgain = 24'($urandom());
          cm_factor = 10'd1000;
          period = 10'd1000;
          ppcm = 16'($urandom());
          linv = 1'b1;
          rinv = 1'b1;
        end
        7: begin
          // Plausible tuning: moderate gains, speeds stay in range
          lgain = 24'($urandom_range(1 << 17));
          rgain = 24'($urandom_range(1 << 17));
          cm_factor = 10'($urandom_range(1, 1000));
          period = 10'($urandom_range(1, 1000));
          ppcm = 16'($urandom_range(1, 4096));
          linv = 1'($urandom());
          rinv = 1'($urandom());
        end
        6, 8: begin
          lgain = 24'($urandom());
          rgain = 24'($urandom());
          cm_factor = 10'($urandom());
          period = 10'($urandom());
          ppcm = 16'($urandom());
          linv = 1'($urandom());
          rinv = 1'($urandom());
        end
        default: ;
      endcase
      write_reg(REG_LEFT_SPEED_GAIN, lgain);
      write_reg(REG_RIGHT_SPEED_GAIN, rgain);
      write_reg(REG_CENTIMETRE_FACTOR, CFG_DATA_W'(cm_factor));
      write_reg(REG_TICK_PERIOD, CFG_DATA_W'(period));
      write_reg(REG_PULSES_PER_CENTIMETRE, CFG_DATA_W'(ppcm));
      write_reg(REG_LEFT_INVERT, CFG_DATA_W'(linv));
      write_reg(REG_RIGHT_INVERT, CFG_DATA_W'(rinv));
      cfg_we <= 1'b0;

      cruise_l = int'($urandom_range(6000)) - 3000;
      cruise_r = int'($urandom_range(6000)) - 3000;
      for (int n = 0; n < PHASE_BEATS; n++) begin
        pick = $urandom_range(99);
        if (floor_phase && n < FLOOR_BEATS) mode = DRIVE_FLOOR;
        else if (pick < 40) mode = DRIVE_NOISE;
        else if (pick < 80) mode = DRIVE_CRUISE;
        else if (pick < 92) mode = DRIVE_EXTREME;
        else mode = DRIVE_FLOOR;
        if (floor_dir == 0) floor_dir = ($urandom_range(1) == 0) ? 1 : -1;
        case (mode)
          DRIVE_NOISE: beat = esde_in_t'($urandom());
          DRIVE_CRUISE: begin
            beat.left_pulses = 16'(cruise_l + int'($urandom_range(64)) - 32);
            beat.right_pulses = 16'(cruise_r + int'($urandom_range(64)) - 32);
          end
          DRIVE_EXTREME: begin
            beat.left_pulses = pick_extreme();
            beat.right_pulses = pick_extreme();
          end
          default: begin
            // Full throttle in one direction; right count opposes for the inverted side
            beat.left_pulses = (floor_dir > 0) ? 16'sh7FFF : 16'sh8000;
            beat.right_pulses = (floor_dir > 0) ? 16'sh8000 : 16'sh7FFF;
          end
        endcase
        send_beat(beat);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

[filelist.f]
sv/esde_pkg.sv
sv/esde_cfg.sv
sv/esde_ctrl.sv
sv/esde_dp.sv
sv/encoder_speed_distance_estimator_unit.sv
sv/esde_checker.sv
test/encoder_speed_distance_estimator_checker.sv
test/encoder_speed_distance_estimator_unit_tb.sv
